// ----- hdl/tknk_pkg.sv -----
// Shared types and constants for the top-k nearest keeper.
// No dependencies; imported by tknk_slots and top_k_nearest_keeper_core.
package tknk_pkg;

    localparam int K_ENTRIES = 5;
    localparam int PTR_W     = 3;
    localparam int IDX_W     = (K_ENTRIES > 1) ? $clog2(K_ENTRIES) : 1;
    localparam int DIST_W    = 32;
    localparam int OP_W      = 2;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_VIC,
        ST_SIFT,
        ST_SCAN_MAX,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic              en;
        logic [PTR_W-1:0]  addr;
        logic [DIST_W-1:0] distance;
        logic              label;
    } t_slot_wr;

endpackage

// ----- hdl/tknk_slots.sv -----
// Slot register file: K_ENTRIES distance/label pairs, one write and one read port.
// Depends on tknk_pkg.
module tknk_slots import tknk_pkg::*; (
    input  logic              i_clk,
    input  t_slot_wr          i_wr,
    input  logic [PTR_W-1:0]  i_rd_addr,
    output logic [DIST_W-1:0] o_rd_dist,
    output logic              o_rd_label
);

    logic [DIST_W-1:0] r_dist  [K_ENTRIES];
    logic              r_label [K_ENTRIES];
    logic              rd_ok;
    logic              wr_ok;

    assign wr_ok = i_wr.en && (i_wr.addr < PTR_W'(K_ENTRIES));
    assign rd_ok = i_rd_addr < PTR_W'(K_ENTRIES);

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_dist[i_wr.addr[IDX_W-1:0]]  <= i_wr.distance;
            r_label[i_wr.addr[IDX_W-1:0]] <= i_wr.label;
        end
    end

    assign o_rd_dist  = rd_ok ? r_dist[i_rd_addr[IDX_W-1:0]] : '0;
    assign o_rd_label = rd_ok ? r_label[i_rd_addr[IDX_W-1:0]] : 1'b0;

endmodule

// ----- hdl/top_k_nearest_keeper_core.sv -----
// Top-k nearest keeper: min-heap candidate set with a shared compare sequencer.
// Depends on tknk_pkg and tknk_slots.
//
// channel  | handshake                | word
// ---------+--------------------------+-------------------------------------------------
// command  | start, busy              | i_operation, i_distance, i_fraud_flag, i_entry_index
// result   | o_valid (one-cycle pulse)| o_accepted, o_count, o_max_distance,
//          |                          | o_read_distance, o_read_fraud
//
// A word is taken when start is high and busy is low; busy stays high until the result.
// Clear, read and rejected push go straight to the result state. A push into a set that
// is not full sifts up; a replacing push scans the K slots for the victim, sifts up, then
// rescans for the new maximum. The single slot read port and comparator do one step per cycle.
// Synchronous active-low reset empties the set. The receiver cannot stall the result.
module top_k_nearest_keeper_core import tknk_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [DIST_W-1:0] i_distance,
    input  logic              i_fraud_flag,
    input  logic [2:0]        i_entry_index,
    output logic              o_valid,
    output logic              o_accepted,
    output logic [2:0]        o_count,
    output logic [DIST_W-1:0] o_max_distance,
    output logic [DIST_W-1:0] o_read_distance,
    output logic              o_read_fraud
);

    t_state            r_state, n_state;
    logic [OP_W-1:0]   r_op, n_op;
    logic [PTR_W-1:0]  r_idx, n_idx;
    logic [PTR_W-1:0]  r_pos, n_pos;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [PTR_W-1:0]  r_best, n_best;
    logic [DIST_W-1:0] r_best_d, n_best_d;
    logic [DIST_W-1:0] r_mov_d, n_mov_d;
    logic              r_mov_f, n_mov_f;
    logic [PTR_W-1:0]  r_count, n_count;
    logic [DIST_W-1:0] r_max, n_max;
    logic              r_acc, n_acc;
    logic              r_repl, n_repl;
    logic              r_o_valid, n_o_valid;
    logic              r_o_acc, n_o_acc;
    logic [PTR_W-1:0]  r_o_count, n_o_count;
    logic [DIST_W-1:0] r_o_max, n_o_max;
    logic [DIST_W-1:0] r_o_rd, n_o_rd;
    logic              r_o_rf, n_o_rf;

    t_slot_wr          slot_wr;
    logic [PTR_W-1:0]  rd_addr;
    logic [DIST_W-1:0] rd_dist;
    logic              rd_label;
    logic [PTR_W-1:0]  parent;
    logic [DIST_W-1:0] cmp_a;
    logic [DIST_W-1:0] cmp_b;
    logic              gt;
    logic              take;

    tknk_slots u_slots (
        .i_clk      (i_clk),
        .i_wr       (slot_wr),
        .i_rd_addr  (rd_addr),
        .o_rd_dist  (rd_dist),
        .o_rd_label (rd_label)
    );

    assign busy   = (r_state != ST_IDLE);
    assign take   = start && !busy;
    assign parent = (r_pos - 1'b1) >> 1;

    assign o_valid         = r_o_valid;
    assign o_accepted      = r_o_acc;
    assign o_count         = r_o_count;
    assign o_max_distance  = r_o_max;
    assign o_read_distance = r_o_rd;
    assign o_read_fraud    = r_o_rf;

    always_comb begin
        unique case (r_state)
            ST_SIFT: rd_addr = parent;
            ST_FIN:  rd_addr = r_idx;
            default: rd_addr = r_ptr;
        endcase
    end

    always_comb begin
        unique case (r_state)
            ST_IDLE: begin
                cmp_a = r_max;
                cmp_b = i_distance;
            end
            ST_SIFT: begin
                cmp_a = rd_dist;
                cmp_b = r_mov_d;
            end
            default: begin
                cmp_a = rd_dist;
                cmp_b = r_best_d;
            end
        endcase
    end

    assign gt = cmp_a > cmp_b;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_ptr     = r_ptr;
        n_best    = r_best;
        n_best_d  = r_best_d;
        n_mov_d   = r_mov_d;
        n_mov_f   = r_mov_f;
        n_count   = r_count;
        n_max     = r_max;
        n_acc     = r_acc;
        n_repl    = r_repl;
        n_o_valid = 1'b0;
        n_o_acc   = r_o_acc;
        n_o_count = r_o_count;
        n_o_max   = r_o_max;
        n_o_rd    = r_o_rd;
        n_o_rf    = r_o_rf;
        slot_wr   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    n_op     = i_operation;
                    n_idx    = i_entry_index;
                    n_mov_d  = i_distance;
                    n_mov_f  = i_fraud_flag;
                    n_acc    = 1'b0;
                    n_repl   = 1'b0;
                    n_ptr    = '0;
                    n_best   = '0;
                    n_best_d = '0;
                    n_state  = ST_FIN;
                    unique case (i_operation)
                        OP_PUSH: begin
                            if (r_count < PTR_W'(K_ENTRIES)) begin
                                n_pos   = r_count;
                                n_count = r_count + 1'b1;
                                n_max   = gt ? r_max : i_distance;
                                n_acc   = 1'b1;
                                n_state = ST_SIFT;
                            end else if (gt) begin
                                n_acc   = 1'b1;
                                n_repl  = 1'b1;
                                n_state = ST_SCAN_VIC;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                            n_max   = '0;
                        end
                        default: begin
                            n_count = r_count;
                        end
                    endcase
                end
            end
            ST_SCAN_VIC: begin
                if (r_ptr >= r_count) begin
                    n_pos   = r_best;
                    n_state = ST_SIFT;
                end else begin
                    if (gt) begin
                        n_best   = r_ptr;
                        n_best_d = rd_dist;
                    end
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_SIFT: begin
                slot_wr.en   = 1'b1;
                slot_wr.addr = r_pos;
                if (r_pos == '0 || !gt) begin
                    slot_wr.distance = r_mov_d;
                    slot_wr.label    = r_mov_f;
                    n_ptr    = '0;
                    n_best   = '0;
                    n_best_d = '0;
                    n_state  = r_repl ? ST_SCAN_MAX : ST_FIN;
                end else begin
                    slot_wr.distance = rd_dist;
                    slot_wr.label    = rd_label;
                    n_pos = parent;
                end
            end
            ST_SCAN_MAX: begin
                if (r_ptr >= r_count) begin
                    n_max   = r_best_d;
                    n_state = ST_FIN;
                end else begin
                    if (gt) begin
                        n_best   = r_ptr;
                        n_best_d = rd_dist;
                    end
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_FIN: begin
                n_o_valid = 1'b1;
                n_o_acc   = r_acc;
                n_o_count = r_count;
                n_o_max   = r_max;
                if (r_op == OP_READ && r_idx < r_count) begin
                    n_o_rd = rd_dist;
                    n_o_rf = rd_label;
                end else begin
                    n_o_rd = '0;
                    n_o_rf = 1'b0;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_max     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_max     <= n_max;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_ptr     <= n_ptr;
        r_best    <= n_best;
        r_best_d  <= n_best_d;
        r_mov_d   <= n_mov_d;
        r_mov_f   <= n_mov_f;
        r_acc     <= n_acc;
        r_repl    <= n_repl;
        r_o_acc   <= n_o_acc;
        r_o_count <= n_o_count;
        r_o_max   <= n_o_max;
        r_o_rd    <= n_o_rd;
        r_o_rf    <= n_o_rf;
    end

`ifndef SYNTH
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PTR_W'(K_ENTRIES))
        else $error("held count beyond set size");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> busy)
        else $error("command taken without going busy");

    a_empty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_count == '0) |-> (o_max_distance == '0))
        else $error("empty set reports a nonzero maximum");
`endif

endmodule

// ----- tb/tb_top_k_nearest_keeper_core.sv -----
`timescale 1ns / 100ps
// Testbench for top_k_nearest_keeper_core: directed and random push, clear and read words,
// checked against an in-bench min-heap keeper by a small scoreboard.
// Depends on tknk_pkg and the core RTL.
module tb_top_k_nearest_keeper_core;
    import tknk_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RANDOM_WORDS = 750;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 30;
    localparam int PRINT_CAP    = 50;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DIST_W-1:0] distance;
        logic              flag;
        logic [2:0]        index;
    } t_command;

    typedef struct {
        logic              accepted;
        logic [2:0]        count;
        logic [DIST_W-1:0] peak;
        logic [DIST_W-1:0] rd_dist;
        logic              rd_flag;
    } t_result_word;

    class nearest_set_scoreboard;
        logic [DIST_W-1:0] heap_dist [K_ENTRIES];
        logic              heap_flag [K_ENTRIES];
        int unsigned       fill;
        logic [DIST_W-1:0] peak;
        t_result_word      expected_words [$];
        int                errors;

        function new();
            empty_set();
            errors = 0;
        endfunction

        function void empty_set();
            for (int n = 0; n < K_ENTRIES; n++) begin
                heap_dist[n] = '0;
                heap_flag[n] = 1'b0;
            end
            fill = 0;
            peak = '0;
        endfunction

        function void sift_up(int unsigned pos);
            int unsigned       up;
            logic [DIST_W-1:0] d;
            logic              f;
            bit                done;
            done = 1'b0;
            while (!done && pos > 0 && pos < K_ENTRIES) begin
                up = (pos - 1) / 2;
                if (heap_dist[up] > heap_dist[pos]) begin
                    d = heap_dist[up];
                    f = heap_flag[up];
                    heap_dist[up] = heap_dist[pos];
                    heap_flag[up] = heap_flag[pos];
                    heap_dist[pos] = d;
                    heap_flag[pos] = f;
                    pos = up;
                end else begin
                    done = 1'b1;
                end
            end
        endfunction

        function int unsigned largest_slot();
            int unsigned best;
            best = 0;
            for (int unsigned n = 1; n < fill && n < K_ENTRIES; n++) begin
                if (heap_dist[n] > heap_dist[best])
                    best = n;
            end
            return best;
        endfunction

        function void note_command(t_command cmd);
            t_result_word w;
            int unsigned  pos;
            w = '{default: '0};
            case (cmd.op)
                OP_PUSH: begin
                    if (fill < K_ENTRIES) begin
                        pos = fill;
                        heap_dist[pos] = cmd.distance;
                        heap_flag[pos] = cmd.flag;
                        fill = pos + 1;
                        sift_up(pos);
                        if (cmd.distance > peak)
                            peak = cmd.distance;
                        w.accepted = 1'b1;
                    end else if (cmd.distance < peak) begin
                        pos = largest_slot();
                        heap_dist[pos] = cmd.distance;
                        heap_flag[pos] = cmd.flag;
                        sift_up(pos);
                        peak = heap_dist[largest_slot()];
                        w.accepted = 1'b1;
                    end
                end
                OP_CLEAR: empty_set();
                OP_READ: begin
                    if (cmd.index < fill) begin
                        w.rd_dist = heap_dist[cmd.index];
                        w.rd_flag = heap_flag[cmd.index];
                    end
                end
                default: ;
            endcase
            w.count = fill[2:0];
            w.peak  = peak;
            expected_words.push_back(w);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        task report_mismatch(string what);
            if (errors < PRINT_CAP)
                $display("%0t ns: mismatch: %s", $time, what);
            errors++;
        endtask

        task compare_field(string name, logic [DIST_W-1:0] got, logic [DIST_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_word(t_result_word got);
            t_result_word want;
            if (expected_words.size() == 0) begin
                report_mismatch("result word with nothing expected");
                return;
            end
            want = expected_words.pop_front();
            compare_field("accepted", DIST_W'(got.accepted), DIST_W'(want.accepted));
            compare_field("count", DIST_W'(got.count), DIST_W'(want.count));
            compare_field("max_distance", got.peak, want.peak);
            compare_field("read_distance", got.rd_dist, want.rd_dist);
            compare_field("read_fraud", DIST_W'(got.rd_flag), DIST_W'(want.rd_flag));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              start         = 1'b0;
    logic [OP_W-1:0]   i_operation   = OP_PUSH;
    logic [DIST_W-1:0] i_distance    = '0;
    logic              i_fraud_flag  = 1'b0;
    logic [2:0]        i_entry_index = '0;
    logic              busy;
    logic              o_valid;
    logic              o_accepted;
    logic [2:0]        o_count;
    logic [DIST_W-1:0] o_max_distance;
    logic [DIST_W-1:0] o_read_distance;
    logic              o_read_fraud;

    nearest_set_scoreboard board;
    t_result_word          seen_word;
    int                    stall_cycles = 0;

    top_k_nearest_keeper_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_distance      (i_distance),
        .i_fraud_flag    (i_fraud_flag),
        .i_entry_index   (i_entry_index),
        .o_valid         (o_valid),
        .o_accepted      (o_accepted),
        .o_count         (o_count),
        .o_max_distance  (o_max_distance),
        .o_read_distance (o_read_distance),
        .o_read_fraud    (o_read_fraud)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_command make_command(logic [OP_W-1:0] op, logic [DIST_W-1:0] distance,
                                              logic flag, logic [2:0] index);
        t_command c;
        c.op       = op;
        c.distance = distance;
        c.flag     = flag;
        c.index    = index;
        return c;
    endfunction

    function automatic t_command random_command();
        t_command c;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 58)
            c.op = OP_PUSH;
        else if (pick < 88)
            c.op = OP_READ;
        else if (pick < 93)
            c.op = OP_CLEAR;
        else
            c.op = OP_SPARE;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            c.distance = $urandom_range(0, 15);
        else if (pick == 4)
            c.distance = ($urandom_range(0, 1) == 0) ? 32'h0
                                                     : 32'hFFFF_FFFF - $urandom_range(0, 2);
        else
            c.distance = $urandom();
        c.flag  = 1'($urandom_range(0, 1));
        c.index = 3'($urandom_range(0, 7));
        return c;
    endfunction

    task automatic issue_command(t_command cmd);
        start         <= 1'b1;
        i_operation   <= cmd.op;
        i_distance    <= cmd.distance;
        i_fraud_flag  <= cmd.flag;
        i_entry_index <= cmd.index;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_command(cmd);
    endtask

    task automatic idle_for(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seen_word.accepted = o_accepted;
            seen_word.count    = o_count;
            seen_word.peak     = o_max_distance;
            seen_word.rd_dist  = o_read_distance;
            seen_word.rd_flag  = o_read_fraud;
            board.check_word(seen_word);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_top_k_nearest_keeper_core NOT OK");
            $finish;
        end
    end

    initial begin
        t_command plan [$];
        t_command cmd;
        int       burst_left;
        int       gap;
        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        plan.push_back(make_command(OP_READ, 32'h0, 1'b0, 3'd0));
        plan.push_back(make_command(OP_SPARE, 32'hFFFF_FFFF, 1'b1, 3'd7));
        plan.push_back(make_command(OP_PUSH, 32'hFFFF_FFFF, 1'b1, 3'd0));
        plan.push_back(make_command(OP_PUSH, 32'h0, 1'b0, 3'd0));
        plan.push_back(make_command(OP_PUSH, 32'd7, 1'b1, 3'd0));
        plan.push_back(make_command(OP_PUSH, 32'd7, 1'b0, 3'd0));
        plan.push_back(make_command(OP_PUSH, 32'd3, 1'b1, 3'd0));
        plan.push_back(make_command(OP_PUSH, 32'hFFFF_FFFF, 1'b0, 3'd0));
        plan.push_back(make_command(OP_PUSH, 32'hFFFF_FFFE, 1'b1, 3'd0));
        plan.push_back(make_command(OP_PUSH, 32'd7, 1'b0, 3'd0));
        plan.push_back(make_command(OP_PUSH, 32'd7, 1'b1, 3'd0));
        for (int n = 0; n < 8; n++)
            plan.push_back(make_command(OP_READ, 32'h0, 1'b0, n[2:0]));
        plan.push_back(make_command(OP_SPARE, 32'h0, 1'b0, 3'd0));
        plan.push_back(make_command(OP_CLEAR, 32'hFFFF_FFFF, 1'b1, 3'd7));
        plan.push_back(make_command(OP_READ, 32'h0, 1'b0, 3'd0));
        plan.push_back(make_command(OP_PUSH, 32'h0, 1'b1, 3'd0));
        plan.push_back(make_command(OP_READ, 32'h0, 1'b0, 3'd0));
        for (int n = 0; n < RANDOM_WORDS; n++)
            plan.push_back(random_command());

        burst_left = 0;
        while (plan.size() != 0) begin
            cmd = plan.pop_front();
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                    idle_for(gap);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            issue_command(cmd);
        end
        start <= 1'b0;

        while (board.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.errors == 0)
            $display("tb_top_k_nearest_keeper_core OK");
        else
            $display("tb_top_k_nearest_keeper_core NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/tknk_pkg.sv
hdl/tknk_slots.sv
hdl/top_k_nearest_keeper_core.sv
tb/tb_top_k_nearest_keeper_core.sv
